@@ design/pps_pkg.sv @@
// pps_pkg: types and constants shared by the preemptive priority scheduler
// item and result structs, table entry layout, item kind codes
// no dependencies
`timescale 1ns / 1ps

package pps_pkg;

  localparam int PC_W    = 5;
  localparam int SLOT_W  = 4;
  localparam int BURST_W = 8;
  localparam int TIME_W  = 16;
  localparam int PRIO_W  = 8;
  localparam int SUM_W   = 32;

  localparam logic [PC_W-1:0] PC_RESET = 5'd1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0]  slot;
    logic [BURST_W-1:0] burst_length;
    logic [TIME_W-1:0]  arrival_time;
    logic [PRIO_W-1:0]  priority_level;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] running_slot;
    logic              idle;
    logic              all_done;
    logic [TIME_W-1:0] current_time;
    logic [SUM_W-1:0]  total_waiting;
    logic [SUM_W-1:0]  total_turnaround;
  } result_t;

  typedef struct packed {
    logic [BURST_W-1:0] remaining;
    logic [TIME_W-1:0]  arrival;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

endpackage

@@ design/preemptive_priority_scheduler_top.sv @@
// preemptive_priority_scheduler_top: sequencer, totals and result register
// depends on pps_pkg, pps_proc_table and pps_scan_unit
//
// usage: an item is taken when start is high and busy is low. a load item
// writes one table slot in the accepting cycle and leaves busy low, so loads
// may follow every cycle. a tick item walks the slots in use through the single
// read port of the table, one slot per cycle, then decides, writes back the
// chosen slot's burst and forms the result; busy stays high through the scan and
// the drain, decide and result states, N = min(process_count, MAX_PROCESSES) slots
// scanned; when no slot is in use only the decide and result states are passed.
// the result is shown for exactly one cycle with result_strobe_o, in the cycle
// in which busy falls; the receiver must take it then, it cannot stall the block.
// load items produce no result. process_count is written on the cfg channel,
// always ready, and must only change while the block is idle.
// reset clears time, totals, the current process and sets process_count to 1.
// the table has no clearing pass: slots are undefined until loaded.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_top import pps_pkg::*; #(
  parameter int MAX_PROCESSES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  in_item_t        in_item_i,
  output logic            result_strobe_o,
  output result_t         result_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [PC_W-1:0] cfg_data_i
);

  localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CW = $clog2(MAX_PROCESSES + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [PC_W-1:0]   pc_q, pc_d;
  logic [IW-1:0]     cur_slot_q, cur_slot_d;
  logic              cur_valid_q, cur_valid_d;
  logic [TIME_W-1:0] tick_q, tick_d;
  logic [SUM_W-1:0]  waiting_q, waiting_d;
  logic [SUM_W-1:0]  burst_sum_q, burst_sum_d;
  logic              strobe_q, strobe_d;

  logic [TIME_W-1:0] now_q, now_d;
  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     rd_idx_q, rd_idx_d;
  logic              eval_q, eval_d;
  logic [IW-1:0]     eval_idx_q, eval_idx_d;
  logic [SLOT_W-1:0] dec_slot_q, dec_slot_d;
  logic              dec_idle_q, dec_idle_d;
  logic              dec_done_q, dec_done_d;
  result_t           result_q, result_d;

  logic          accept;
  logic          slot_ok;
  logic [CW-1:0] count_in_use;
  logic          scan_clear;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_data;

  logic          best_valid;
  logic [IW-1:0] best_idx;
  entry_t        best_entry;
  logic          cur_ready;
  entry_t        cur_entry;
  logic [CW-1:0] ready_cnt;
  logic [CW-1:0] busy_cnt;

  logic            use_cur;
  logic [IW-1:0]   chosen_idx;
  entry_t          chosen_entry;
  logic            last_tick_of_chosen;
  logic [CW-1:0]   wait_inc;
  logic [SUM_W:0]  wait_sum;
  logic [SUM_W:0]  turn_sum;
  logic [SUM_W:0]  burst_acc;

  assign accept       = start && !busy;
  assign slot_ok      = (int'(in_item_i.slot) < MAX_PROCESSES);
  assign count_in_use = (int'(pc_q) > MAX_PROCESSES) ? CW'(MAX_PROCESSES) : CW'(pc_q);
  assign scan_clear   = accept && (in_item_i.kind == KIND_TICK);

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // decision from the finished scan
  assign use_cur      = cur_ready && !(best_entry.prio < cur_entry.prio);
  assign chosen_idx   = use_cur ? cur_slot_q : best_idx;
  assign chosen_entry = use_cur ? cur_entry : best_entry;
  assign last_tick_of_chosen = best_valid && (chosen_entry.remaining == BURST_W'(1));
  assign wait_inc     = best_valid ? (ready_cnt - 1'b1) : '0;
  assign wait_sum     = {1'b0, waiting_q} + (SUM_W + 1)'(wait_inc);
  assign turn_sum     = {1'b0, waiting_q} + {1'b0, burst_sum_q};
  assign burst_acc    = {1'b0, burst_sum_q} + (SUM_W + 1)'(in_item_i.burst_length);

  // table write: loads in idle, burst write-back when deciding
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = IW'(in_item_i.slot);
    wr_data = '{remaining: in_item_i.burst_length,
                arrival:   in_item_i.arrival_time,
                prio:      in_item_i.priority_level};
    if (state_q == ST_DECIDE) begin
      wr_en   = best_valid;
      wr_addr = chosen_idx;
      wr_data = '{remaining: chosen_entry.remaining - 1'b1,
                  arrival:   chosen_entry.arrival,
                  prio:      chosen_entry.prio};
    end else if (accept && (in_item_i.kind == KIND_LOAD) && slot_ok) begin
      wr_en = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    cur_slot_d  = cur_slot_q;
    cur_valid_d = cur_valid_q;
    tick_d      = tick_q;
    waiting_d   = waiting_q;
    burst_sum_d = burst_sum_q;
    strobe_d    = 1'b0;
    now_d       = now_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    eval_d      = 1'b0;
    eval_idx_d  = eval_idx_q;
    dec_slot_d  = dec_slot_q;
    dec_idle_d  = dec_idle_q;
    dec_done_d  = dec_done_q;
    result_d    = result_q;

    if (cfg_valid_i && cfg_ready_o) begin
      pc_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_item_i.kind == KIND_LOAD) begin
            if (slot_ok) begin
              burst_sum_d = burst_acc[SUM_W] ? '1 : burst_acc[SUM_W-1:0];
            end
          end else begin
            now_d    = tick_q;
            count_d  = count_in_use;
            rd_idx_d = '0;
            if (tick_q != '1) begin
              tick_d = tick_q + 1'b1;
            end
            state_d = (count_in_use == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        eval_d     = 1'b1;
        eval_idx_d = rd_idx_q;
        if (CW'(rd_idx_q) == (count_q - 1'b1)) begin
          state_d = ST_DRAIN;
        end else begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cur_valid_d = best_valid;
        if (best_valid) begin
          cur_slot_d = chosen_idx;
          waiting_d  = wait_sum[SUM_W] ? '1 : wait_sum[SUM_W-1:0];
        end
        dec_slot_d = best_valid ? SLOT_W'(chosen_idx) : '0;
        dec_idle_d = !best_valid;
        dec_done_d = ((busy_cnt - CW'(last_tick_of_chosen)) == '0);
        state_d    = ST_RESULT;
      end
      ST_RESULT: begin
        result_d.running_slot     = dec_slot_q;
        result_d.idle             = dec_idle_q;
        result_d.all_done         = dec_done_q;
        result_d.current_time     = now_q;
        result_d.total_waiting    = waiting_q;
        result_d.total_turnaround = turn_sum[SUM_W] ? '1 : turn_sum[SUM_W-1:0];
        strobe_d = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= PC_RESET;
      cur_slot_q  <= '0;
      cur_valid_q <= 1'b0;
      tick_q      <= '0;
      waiting_q   <= '0;
      burst_sum_q <= '0;
      strobe_q    <= 1'b0;
      rd_idx_q    <= '0;
      eval_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      cur_slot_q  <= cur_slot_d;
      cur_valid_q <= cur_valid_d;
      tick_q      <= tick_d;
      waiting_q   <= waiting_d;
      burst_sum_q <= burst_sum_d;
      strobe_q    <= strobe_d;
      rd_idx_q    <= rd_idx_d;
      eval_q      <= eval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    count_q    <= count_d;
    eval_idx_q <= eval_idx_d;
    dec_slot_q <= dec_slot_d;
    dec_idle_q <= dec_idle_d;
    dec_done_q <= dec_done_d;
    result_q   <= result_d;
  end

  pps_proc_table #(
    .DEPTH (MAX_PROCESSES),
    .IW    (IW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_idx_q),
    .rd_data_o (rd_data)
  );

  pps_scan_unit #(
    .IW (IW),
    .CW (CW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (scan_clear),
    .eval_i       (eval_q),
    .eval_idx_i   (eval_idx_q),
    .entry_i      (rd_data),
    .now_i        (now_q),
    .cur_valid_i  (cur_valid_q),
    .cur_slot_i   (cur_slot_q),
    .best_valid_o (best_valid),
    .best_idx_o   (best_idx),
    .best_entry_o (best_entry),
    .cur_ready_o  (cur_ready),
    .cur_entry_o  (cur_entry),
    .ready_cnt_o  (ready_cnt),
    .busy_cnt_o   (busy_cnt)
  );

  assign result_strobe_o = strobe_q;
  assign result_o        = result_q;

`ifndef SYNTH
  a_strobe_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(state_q == ST_RESULT))
    else $error("result strobe without a finished tick");

  a_idle_slot_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && result_o.idle) |-> (result_o.running_slot == '0))
    else $error("idle result carries a slot");

  a_turn_ge_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> (result_o.total_turnaround >= result_o.total_waiting))
    else $error("turnaround below waiting total");

  a_eval_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_q |-> (CW'(eval_idx_q) < count_q))
    else $error("scan evaluated a slot outside the slots in use");

  a_no_writeback_idle_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DECIDE) && !best_valid) |=> !cur_valid_q)
    else $error("current process kept after an idle tick");
`endif

endmodule

@@ design/pps_proc_table.sv @@
// pps_proc_table: process table memory, one write and one registered read port
// depends on pps_pkg for the entry layout
`timescale 1ns / 1ps

module pps_proc_table import pps_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [IW-1:0] wr_addr_i,
  input  entry_t        wr_data_i,
  input  logic [IW-1:0] rd_addr_i,
  output entry_t        rd_data_o
);

  entry_t mem [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/pps_scan_unit.sv @@
// pps_scan_unit: evaluates one table entry per cycle while eval_i is high and keeps the running best
// ready process, ready and unfinished counts, and the entry of the current slot
// depends on pps_pkg
`timescale 1ns / 1ps

module pps_scan_unit import pps_pkg::*; #(
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              eval_i,
  input  logic [IW-1:0]     eval_idx_i,
  input  entry_t            entry_i,
  input  logic [TIME_W-1:0] now_i,
  input  logic              cur_valid_i,
  input  logic [IW-1:0]     cur_slot_i,
  output logic              best_valid_o,
  output logic [IW-1:0]     best_idx_o,
  output entry_t            best_entry_o,
  output logic              cur_ready_o,
  output entry_t            cur_entry_o,
  output logic [CW-1:0]     ready_cnt_o,
  output logic [CW-1:0]     busy_cnt_o
);

  logic          best_valid_q, best_valid_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  entry_t        best_entry_q, best_entry_d;
  logic          cur_ready_q, cur_ready_d;
  entry_t        cur_entry_q, cur_entry_d;
  logic [CW-1:0] ready_cnt_q, ready_cnt_d;
  logic [CW-1:0] busy_cnt_q, busy_cnt_d;

  logic unfinished;
  logic ready;

  assign unfinished = (entry_i.remaining != '0);
  assign ready      = unfinished && (entry_i.arrival <= now_i);

  always_comb begin
    best_valid_d = best_valid_q;
    best_idx_d   = best_idx_q;
    best_entry_d = best_entry_q;
    cur_ready_d  = cur_ready_q;
    cur_entry_d  = cur_entry_q;
    ready_cnt_d  = ready_cnt_q;
    busy_cnt_d   = busy_cnt_q;
    if (clear_i) begin
      best_valid_d = 1'b0;
      cur_ready_d  = 1'b0;
      ready_cnt_d  = '0;
      busy_cnt_d   = '0;
    end else if (eval_i) begin
      if (unfinished) begin
        busy_cnt_d = busy_cnt_q + 1'b1;
      end
      // strict compare keeps the lowest slot on equal priority
      if (ready) begin
        ready_cnt_d = ready_cnt_q + 1'b1;
        if (!best_valid_q || (entry_i.prio < best_entry_q.prio)) begin
          best_valid_d = 1'b1;
          best_idx_d   = eval_idx_i;
          best_entry_d = entry_i;
        end
      end
      if (cur_valid_i && (eval_idx_i == cur_slot_i)) begin
        cur_ready_d = ready;
        cur_entry_d = entry_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q <= 1'b0;
      cur_ready_q  <= 1'b0;
      ready_cnt_q  <= '0;
      busy_cnt_q   <= '0;
    end else begin
      best_valid_q <= best_valid_d;
      cur_ready_q  <= cur_ready_d;
      ready_cnt_q  <= ready_cnt_d;
      busy_cnt_q   <= busy_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q   <= best_idx_d;
    best_entry_q <= best_entry_d;
    cur_entry_q  <= cur_entry_d;
  end

  assign best_valid_o = best_valid_q;
  assign best_idx_o   = best_idx_q;
  assign best_entry_o = best_entry_q;
  assign cur_ready_o  = cur_ready_q;
  assign cur_entry_o  = cur_entry_q;
  assign ready_cnt_o  = ready_cnt_q;
  assign busy_cnt_o   = busy_cnt_q;

endmodule
